// ===== design/stc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the exp2 table of the softmax threshold classifier
// no dependencies
package stc_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int IDX_W       = 2;
    localparam int DIV_STAGES  = 6;
    localparam int DIV_BITS    = 3;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_SCALE     = 3'd0,
        REG_ENABLE    = 3'd1,
        REG_THRESH0   = 3'd2,
        REG_THRESH1   = 3'd3,
        REG_THRESH2   = 3'd4,
        REG_MAX_DET   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [7:0] logit_zero;
        logic signed [7:0] logit_one;
        logic signed [7:0] logit_two;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  class_index;
        logic [16:0] confidence;
        logic        accepted;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic signed [4:0]                scale_exponent;
        logic [NUM_CLASSES-1:0]           class_enable;
        logic [NUM_CLASSES-1:0][16:0]     threshold;
        logic [1:0]                       max_detections;
    } t_cfg;

    // one division lane: partial remainder, numerator bits still to shift in, quotient
    typedef struct packed {
        logic [17:0] rem;
        logic [17:0] nlow;
        logic [17:0] q;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [NUM_CLASSES-1:0] lane;
        logic [17:0]                 divisor;
    } t_div_stage;

    // round(65536 * 2^(-j/16))
    function automatic logic [16:0] pow2_tab(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/softmax_threshold_classifier.sv =====
`timescale 1ns / 1ps
// Softmax classifier over three int8 logits with per-class thresholds. An item
// passes five front stages (max, multiply, table, interpolate, sum) and six
// divider stages, then loads the output serialiser, from which its three class
// results leave one after another as the result port takes them. The pipeline
// moves as one and takes a new item whenever the output serialiser can load;
// the result port emits three transactions per item. Configuration writes are
// meant for an idle block.
// depends on stc_pkg, stc_cfg, stc_exp, stc_div, stc_out
module softmax_threshold_classifier (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  stc_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output stc_pkg::t_out_item    o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    stc_pkg::t_cfg       w_cfg;
    stc_pkg::t_div_stage w_exp_div;
    stc_pkg::t_div_stage w_div_out;
    logic                w_exp_v;
    logic                w_div_v;
    logic                w_en;

    assign o_in_stall = !w_en;

    stc_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg (w_cfg)
    );

    stc_exp u_exp (
        .i_clk, .i_rst_n,
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (w_cfg),
        .o_valid (w_exp_v),
        .o_div   (w_exp_div)
    );

    stc_div u_div (
        .i_clk, .i_rst_n,
        .i_en    (w_en),
        .i_valid (w_exp_v),
        .i_div   (w_exp_div),
        .o_valid (w_div_v),
        .o_div   (w_div_out)
    );

    stc_out u_out (
        .i_clk, .i_rst_n,
        .i_valid     (w_div_v),
        .i_div       (w_div_out),
        .i_cfg       (w_cfg),
        .o_ready     (w_en),
        .o_out_valid,
        .i_out_stall,
        .o_out_item
    );

endmodule

// ===== design/stc_cfg.sv =====
`timescale 1ns / 1ps
// configuration register file behind the apb-style port
// depends on stc_pkg
module stc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output stc_pkg::t_cfg     o_cfg
);

    stc_pkg::t_cfg r_cfg;
    stc_pkg::t_reg_idx w_idx;

    assign w_idx  = stc_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_exponent <= 5'sd0;
            r_cfg.class_enable   <= 3'd7;
            r_cfg.threshold      <= {3{17'd32768}};
            r_cfg.max_detections <= 2'd3;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                stc_pkg::REG_SCALE:   r_cfg.scale_exponent <= pwdata[4:0];
                stc_pkg::REG_ENABLE:  r_cfg.class_enable   <= pwdata[2:0];
                stc_pkg::REG_THRESH0: r_cfg.threshold[0]   <= pwdata[16:0];
                stc_pkg::REG_THRESH1: r_cfg.threshold[1]   <= pwdata[16:0];
                stc_pkg::REG_THRESH2: r_cfg.threshold[2]   <= pwdata[16:0];
                stc_pkg::REG_MAX_DET: r_cfg.max_detections <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            stc_pkg::REG_SCALE:   prdata = {27'd0, r_cfg.scale_exponent};
            stc_pkg::REG_ENABLE:  prdata = {29'd0, r_cfg.class_enable};
            stc_pkg::REG_THRESH0: prdata = {15'd0, r_cfg.threshold[0]};
            stc_pkg::REG_THRESH1: prdata = {15'd0, r_cfg.threshold[1]};
            stc_pkg::REG_THRESH2: prdata = {15'd0, r_cfg.threshold[2]};
            stc_pkg::REG_MAX_DET: prdata = {30'd0, r_cfg.max_detections};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/stc_exp.sv =====
`timescale 1ns / 1ps
// front pipeline: max subtraction, exp2 by table and interpolation, sum and dividends
// depends on stc_pkg
module stc_exp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  stc_pkg::t_in_item     i_item,
    input  stc_pkg::t_cfg         i_cfg,
    output logic                  o_valid,
    output stc_pkg::t_div_stage   o_div
);

    localparam int NC = stc_pkg::NUM_CLASSES;

    logic signed [7:0] w_lg [NC];
    logic signed [7:0] w_mx;
    logic [7:0]        n_x  [NC];
    logic [40:0]       w_t  [NC];
    logic [4:0]        w_ne;
    logic [16:0]       w_tj [NC];
    logic [11:0]       w_d  [NC];
    logic [16:0]       w_v  [NC];
    logic [18:0]       w_sum;

    logic [4:0]  r_v;
    logic [7:0]  r_x    [NC];
    logic [24:0] r_y    [NC];
    logic        r_big  [NC];
    logic [4:0]  r_k    [NC];
    logic [16:0] r_tj   [NC];
    logic [23:0] r_prod [NC];
    logic [16:0] r_ex   [NC];
    stc_pkg::t_div_stage r_div;

    assign w_lg[0] = i_item.logit_zero;
    assign w_lg[1] = i_item.logit_one;
    assign w_lg[2] = i_item.logit_two;
    assign w_ne    = 5'(-i_cfg.scale_exponent);

    // stage 1: largest logit and distances from it
    always_comb begin
        w_mx = w_lg[0];
        for (int i = 1; i < NC; i++) begin
            if (w_lg[i] > w_mx) w_mx = w_lg[i];
        end
        for (int i = 0; i < NC; i++) begin
            n_x[i] = 8'(9'(w_mx) - 9'(w_lg[i]));
        end
    end

    // stage 3 logic: power-of-two scaling and table lookup
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (!i_cfg.scale_exponent[4]) w_t[i] = 41'(r_y[i]) << i_cfg.scale_exponent[3:0];
            else                          w_t[i] = 41'(r_y[i]) >> w_ne;
            w_tj[i] = stc_pkg::pow2_tab({1'b0, w_t[i][15:12]});
            w_d[i]  = 12'(w_tj[i] - stc_pkg::pow2_tab(5'({1'b0, w_t[i][15:12]}) + 5'd1));
        end
    end

    // stage 4 logic: interpolate and shift by the integer part
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            w_v[i] = r_tj[i] - 17'(r_prod[i] >> 12);
        end
    end

    // stage 5 logic: sum of exponentials
    always_comb begin
        w_sum = 19'd0;
        for (int i = 0; i < NC; i++) begin
            w_sum = w_sum + 19'(r_ex[i]);
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // pipeline data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= 25'(r_x[i]) * 25'(stc_pkg::LOG2E_Q16);
                r_big[i]  <= (w_t[i][40:16] > 25'd16);
                r_k[i]    <= w_t[i][20:16];
                r_tj[i]   <= w_tj[i];
                r_prod[i] <= 24'(w_d[i]) * 24'(w_t[i][11:0]);
                r_ex[i]   <= r_big[i] ? 17'd0 : (w_v[i] >> r_k[i]);
                r_div.lane[i].rem  <= {3'd0, 15'(({r_ex[i], 16'd0} + 33'(w_sum >> 1)) >> 18)};
                r_div.lane[i].nlow <= 18'({r_ex[i], 16'd0} + 33'(w_sum >> 1));
                r_div.lane[i].q    <= 18'd0;
            end
            r_div.divisor <= w_sum[17:0];
        end
    end

    assign o_valid = r_v[4];
    assign o_div   = r_div;

endmodule

// ===== design/stc_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, three quotient bits per stage, one lane per class
// depends on stc_pkg
module stc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  stc_pkg::t_div_stage   i_div,
    output logic                  o_valid,
    output stc_pkg::t_div_stage   o_div
);

    localparam int NS = stc_pkg::DIV_STAGES;

    stc_pkg::t_div_stage r_st [NS];
    stc_pkg::t_div_stage n_st [NS];
    logic [NS-1:0]       r_v;

    function automatic stc_pkg::t_div_lane div_step(input stc_pkg::t_div_lane l,
                                                    input logic [17:0] d);
        stc_pkg::t_div_lane o;
        logic [18:0] t;
        t = {l.rem, l.nlow[17]};
        o.nlow = {l.nlow[16:0], 1'b0};
        if (t >= {1'b0, d}) begin
            o.rem = 18'(t - {1'b0, d});
            o.q   = {l.q[16:0], 1'b1};
        end else begin
            o.rem = t[17:0];
            o.q   = {l.q[16:0], 1'b0};
        end
        return o;
    endfunction

    // quotient bits for every stage
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_st[s] = (s == 0) ? i_div : r_st[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < stc_pkg::DIV_BITS; b++) begin
                for (int i = 0; i < stc_pkg::NUM_CLASSES; i++) begin
                    n_st[s].lane[i] = div_step(n_st[s].lane[i], n_st[s].divisor);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_div   = r_st[NS-1];

endmodule

// ===== design/stc_out.sv =====
`timescale 1ns / 1ps
// threshold decision and result serialiser, one class result per transaction
// depends on stc_pkg
module stc_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  stc_pkg::t_div_stage   i_div,
    input  stc_pkg::t_cfg         i_cfg,
    output logic                  o_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output stc_pkg::t_out_item    o_out_item
);

    localparam int NC = stc_pkg::NUM_CLASSES;
    localparam logic [stc_pkg::IDX_W-1:0] LAST_IDX = stc_pkg::IDX_W'(NC - 1);

    logic [NC-1:0] n_acc;
    logic [1:0]    w_cnt;
    logic          r_busy;
    logic [stc_pkg::IDX_W-1:0] r_idx;
    logic [16:0]   r_conf [NC];
    logic [NC-1:0] r_acc;
    logic          w_done;

    // acceptance in class order with a running count
    always_comb begin
        w_cnt = 2'd0;
        for (int i = 0; i < NC; i++) begin
            n_acc[i] = i_cfg.class_enable[i]
                       && ({1'b0, i_div.lane[i].q[16:0]} >= {1'b0, i_cfg.threshold[i]})
                       && (w_cnt < i_cfg.max_detections);
            w_cnt = w_cnt + 2'(n_acc[i]);
        end
    end

    assign w_done  = r_busy && !i_out_stall && (r_idx == LAST_IDX);
    assign o_ready = !r_busy || w_done;

    // serialiser control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_idx  <= '0;
        end else if (!i_out_stall) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int i = 0; i < NC; i++) begin
                r_conf[i] <= i_div.lane[i].q[16:0];
            end
            r_acc <= n_acc;
        end
    end

    assign o_out_valid            = r_busy;
    assign o_out_item.class_index = r_idx;
    assign o_out_item.confidence  = r_conf[r_idx];
    assign o_out_item.accepted    = r_acc[r_idx];
    assign o_out_item.last        = (r_idx == LAST_IDX);

endmodule

// ===== design/stc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the softmax threshold classifier, bound to the top level
// depends on stc_pkg
module stc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input stc_pkg::t_out_item o_out_item
);

    // the final result of an item is the last class
    a_last_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.class_index == 2'd2)
        else $error("last flag on wrong class");

    // a taken non-final result is followed by the next class
    a_class_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last |=>
            o_out_valid && o_out_item.class_index == $past(o_out_item.class_index) + 2'd1)
        else $error("class results out of order");

    // probability never exceeds one
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.confidence <= 17'd65536)
        else $error("confidence above one");

    // nothing leaves straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind softmax_threshold_classifier stc_checker u_stc_checker (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_stall, .o_out_item
);
